[hw/rtl/i4dp_pkg.sv]
package i4dp_pkg;

  // Field widths of one input word and one result word
  localparam int ACT_W   = 8;
  localparam int WBYTE_W = 8;
  localparam int ZP_W    = 8;
  localparam int SCALE_W = 32;
  localparam int NIB_W   = 4;
  localparam int PROD_W  = ACT_W + ZP_W;
  localparam int ACC_W   = 32;
  localparam int FULL_W  = ACC_W + SCALE_W;
  localparam int RES_W   = 48;

  // Fraction bits of the scale input and of the scaled result
  localparam int SCALE_FRAC_BITS_DEF = 24;
  localparam int OUT_FRAC_BITS       = 8;

  // Mask for one nibble of the packed weight byte, low or high after a shift
  localparam logic [WBYTE_W-1:0] NIBBLE_MASK = 8'h0F;

  // Command word from the controller to the datapath
  typedef struct packed {
    logic acc_en;    // add one product, flip the nibble select
    logic close_en;  // add the last product, capture sum and scale, clear
    logic mul_en;    // form the full product of sum and scale
    logic sat_en;    // shift and saturate into the result register
  } cmd_t;

endpackage

[hw/rtl/i4dp_if.sv]
// Input channel: one element of the dot product per word
interface i4dp_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [i4dp_pkg::ACT_W-1:0]     activation;
  logic        [i4dp_pkg::WBYTE_W-1:0]   weight_byte;
  logic signed [i4dp_pkg::ZP_W-1:0]      weight_zp;
  logic signed [i4dp_pkg::SCALE_W-1:0]   scale_q24;
  logic                                  last_element;

  modport source (output valid, activation, weight_byte, weight_zp, scale_q24,
                  last_element, input ready);
  modport sink   (input valid, activation, weight_byte, weight_zp, scale_q24,
                  last_element, output ready);
endinterface

// Result channel: one word per finished dot product
interface i4dp_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [i4dp_pkg::ACC_W-1:0]   dot_sum;
  logic signed [i4dp_pkg::RES_W-1:0]   scaled_result;

  modport source (output valid, dot_sum, scaled_result, input ready);
  modport sink   (input valid, dot_sum, scaled_result, output ready);
endinterface

[hw/rtl/i4dp_ctrl.sv]
module i4dp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output i4dp_pkg::cmd_t cmd
);
  import i4dp_pkg::*;

  typedef enum logic [1:0] {
    ST_ACC,
    ST_MUL,
    ST_SAT,
    ST_SEND
  } state_t;

  state_t state;
  logic   accept;

  assign accept = in_valid && in_ready;

  // Decode commands for the datapath
  always_comb begin
    cmd.acc_en   = accept && !in_last;
    cmd.close_en = accept && in_last;
    cmd.mul_en   = (state == ST_MUL);
    cmd.sat_en   = (state == ST_SAT);
  end

  // Hold state and the handshake outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_ACC;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_ACC: begin
          if (accept && in_last) begin
            state    <= ST_MUL;
            in_ready <= 1'b0;
          end
        end
        ST_MUL: begin
          state <= ST_SAT;
        end
        ST_SAT: begin
          state     <= ST_SEND;
          out_valid <= 1'b1;
        end
        ST_SEND: begin
          if (out_ready) begin
            state     <= ST_ACC;
            out_valid <= 1'b0;
            in_ready  <= 1'b1;
          end
        end
        default: begin
          state     <= ST_ACC;
          in_ready  <= 1'b1;
          out_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

[hw/rtl/i4dp_datapath.sv]
module i4dp_datapath #(
  parameter int SCALE_FRAC_BITS = i4dp_pkg::SCALE_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  i4dp_pkg::cmd_t                      cmd,
  input  logic signed [i4dp_pkg::ACT_W-1:0]   activation,
  input  logic        [i4dp_pkg::WBYTE_W-1:0] weight_byte,
  input  logic signed [i4dp_pkg::ZP_W-1:0]    weight_zp,
  input  logic signed [i4dp_pkg::SCALE_W-1:0] scale_q24,
  output logic signed [i4dp_pkg::ACC_W-1:0]   dot_sum,
  output logic signed [i4dp_pkg::RES_W-1:0]   scaled_result
);
  import i4dp_pkg::*;

  localparam int SHIFT = SCALE_FRAC_BITS - OUT_FRAC_BITS;

  localparam logic signed [RES_W-1:0] RES_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic signed [RES_W-1:0] RES_MIN = {1'b1, {(RES_W-1){1'b0}}};

  logic        [ACC_W-1:0]   accumulator;
  logic                      odd_element;
  logic signed [ACC_W-1:0]   sum;
  logic signed [SCALE_W-1:0] scale;
  logic signed [FULL_W-1:0]  product;

  logic        [NIB_W-1:0]   nibble;
  logic signed [ZP_W-1:0]    weight_ext;
  logic signed [ZP_W-1:0]    weight_deq;
  logic signed [PROD_W-1:0]  mac_prod;
  logic        [ACC_W-1:0]   acc_sum;
  logic signed [FULL_W-1:0]  shifted;
  logic                      fits;

  // Pick the nibble, remove the zero point with 8-bit wrap, multiply-add
  always_comb begin
    nibble     = odd_element ? NIB_W'((weight_byte >> NIB_W) & NIBBLE_MASK)
                             : NIB_W'(weight_byte & NIBBLE_MASK);
    weight_ext = {{(ZP_W-NIB_W){nibble[NIB_W-1]}}, nibble};
    weight_deq = weight_ext - weight_zp;
    mac_prod   = activation * weight_deq;
    acc_sum    = accumulator + {{(ACC_W-PROD_W){mac_prod[PROD_W-1]}}, mac_prod};
  end

  // Drop fraction bits, flooring, and check the 48-bit range
  always_comb begin
    shifted = product >>> SHIFT;
    fits    = (shifted[FULL_W-1:RES_W-1] == '0) || (shifted[FULL_W-1:RES_W-1] == '1);
  end

  // Advance the accumulator and nibble select
  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      odd_element <= 1'b0;
    end else if (cmd.close_en) begin
      accumulator <= '0;
      odd_element <= 1'b0;
    end else if (cmd.acc_en) begin
      accumulator <= acc_sum;
      odd_element <= ~odd_element;
    end
  end

  // Capture the sum and scale, multiply, then saturate
  always_ff @(posedge clk) begin
    if (cmd.close_en) begin
      sum   <= acc_sum;
      scale <= scale_q24;
    end
    if (cmd.mul_en) begin
      // signed 32x32 multiply, widened to the 64-bit product by context
      product <= sum * scale;
    end
    if (cmd.sat_en) begin
      if (fits) begin
        scaled_result <= shifted[RES_W-1:0];
      end else if (shifted[FULL_W-1]) begin
        scaled_result <= RES_MIN;
      end else begin
        scaled_result <= RES_MAX;
      end
    end
  end

  assign dot_sum = sum;

endmodule

[hw/rtl/int4_weight_dot_product.sv]
// Quantized dot product with 4-bit weights and an 8-bit zero point per channel.
// Each input word carries one signed activation and the packed weight byte;
// even elements use the low nibble, odd elements the high nibble. Words that
// are not last are taken one per cycle while accumulating and only update the
// 32-bit wrapping accumulator. A last word closes the sum: the block then stops
// taking input, performs the 32x32 scale multiply and then the shift and 48-bit
// saturation, and presents dot_sum and scaled_result (8 fraction bits) until
// the result word is taken, and only then takes input again. The accumulator
// and nibble select restart at zero and even after every last word.
module int4_weight_dot_product #(
  parameter int SCALE_FRAC_BITS = i4dp_pkg::SCALE_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  i4dp_in_if.sink     items,
  i4dp_out_if.source  results
);
  import i4dp_pkg::*;

  cmd_t cmd;

  // Sequence the accumulate, multiply and saturate steps
  i4dp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (items.valid),
    .in_last   (items.last_element),
    .in_ready  (items.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .cmd       (cmd)
  );

  // Hold the accumulator and the scale arithmetic
  i4dp_datapath #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .activation    (items.activation),
    .weight_byte   (items.weight_byte),
    .weight_zp     (items.weight_zp),
    .scale_q24     (items.scale_q24),
    .dot_sum       (results.dot_sum),
    .scaled_result (results.scaled_result)
  );

endmodule
